### src/fpba_pkg.sv
// Shared types, constants and codes for the fit-policy block allocator.
package fpba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_BITS  = 16;
    localparam int SZ_W       = ADDR_BITS + 1;
    localparam int HDR_W      = 7;
    localparam int POL_W      = 2;
    localparam int ST_W       = 3;
    localparam int MRG_W      = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [SZ_W-1:0]  HEAP_SPAN   = SZ_W'(1) << ADDR_BITS;
    localparam logic [HDR_W-1:0] HDR_MASK    = 7'h7C;
    localparam logic [SZ_W-1:0]  ALIGN_MASK  = ~(SZ_W'(3));
    localparam logic [SZ_W-1:0]  ALIGN_ADD   = SZ_W'(3);
    localparam logic [SZ_W:0]    SPLIT_SLACK = (SZ_W+1)'(4);

    // register indexes
    localparam logic [1:0] REG_FIT_POLICY   = 2'd0;
    localparam logic [1:0] REG_HEAP_LIMIT   = 2'd1;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

    // fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POL_W-1:0] POL_WORST = 2'd3;

    // operations
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status
    localparam logic [ST_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [ST_W-1:0] ST_FREED     = 3'd1;
    localparam logic [ST_W-1:0] ST_ZERO      = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_MEM    = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] len;
        logic            free;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_INS,
        CELL_DEL,
        CELL_WR
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EXEC1,
        S_EXEC2,
        S_EXEC3,
        S_DONE
    } t_state;

endpackage

### src/fpba_cell.sv
// One table cell: holds a block entry and moves it to or from its neighbours.
module fpba_cell (
    input  logic                         i_clk,
    input  logic [fpba_pkg::IDX_W-1:0]   i_index,
    input  fpba_pkg::t_cell_cmd          i_cmd,
    input  fpba_pkg::t_entry             i_left,
    input  fpba_pkg::t_entry             i_right,
    output fpba_pkg::t_entry             o_ent
);

    fpba_pkg::t_entry r_ent;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fpba_pkg::CELL_ROT: begin
                r_ent <= i_right;
            end
            fpba_pkg::CELL_INS: begin
                if (i_index > i_cmd.idx) begin
                    r_ent <= i_left;
                end else if (i_index == i_cmd.idx) begin
                    r_ent <= i_cmd.ent;
                end
            end
            fpba_pkg::CELL_DEL: begin
                // last cell keeps its (now unused) contents
                if (i_index >= i_cmd.idx &&
                    i_index != fpba_pkg::IDX_W'(fpba_pkg::MAX_BLOCKS - 1)) begin
                    r_ent <= i_right;
                end
            end
            fpba_pkg::CELL_WR: begin
                if (i_index == i_cmd.idx) begin
                    r_ent <= i_cmd.ent;
                end
            end
            default: begin
                r_ent <= r_ent;
            end
        endcase
    end

    assign o_ent = r_ent;

endmodule

### src/fpba_table.sv
// Row of block cells; cell 0 is the head seen by the controller.
module fpba_table (
    input  logic                 i_clk,
    input  fpba_pkg::t_cell_cmd  i_cmd,
    output fpba_pkg::t_entry     o_head
);

    fpba_pkg::t_entry w_ent [fpba_pkg::MAX_BLOCKS];

    for (genvar k = 0; k < fpba_pkg::MAX_BLOCKS; k++) begin : g_cell
        fpba_cell u_cell (
            .i_clk   (i_clk),
            .i_index (fpba_pkg::IDX_W'(k)),
            .i_cmd   (i_cmd),
            .i_left  (w_ent[(k + fpba_pkg::MAX_BLOCKS - 1) % fpba_pkg::MAX_BLOCKS]),
            .i_right (w_ent[(k + 1) % fpba_pkg::MAX_BLOCKS]),
            .o_ent   (w_ent[k])
        );
    end

    assign o_head = w_ent[0];

endmodule

### src/fit_policy_block_allocator.sv
// Top level: block allocator with configuration port, sequencer and cell table.
// Each transaction passes the scan, decide and execute states (a zero-size allocate
// goes straight to the result): the block table is rotated once through the head
// cell to search it, the decide state settles the outcome and EXEC1 to EXEC3 apply
// inserts, deletes and writes to the row of cells. One transaction is handled at a
// time; a finished result waits in the output register while the next one is taken.
module fit_policy_block_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fpba_pkg::PADDR_W-1:0]      paddr,
    input  logic [fpba_pkg::PDATA_W-1:0]      pwdata,
    output logic [fpba_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [15:0]                       i_request_size,
    input  logic [15:0]                       i_free_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic [15:0]                       o_data_address,
    output logic [16:0]                       o_granted_size,
    output logic                              o_heap_grew,
    output logic                              o_block_split,
    output logic [1:0]                        o_merges_done
);

    localparam int IW = fpba_pkg::IDX_W;
    localparam int CW = fpba_pkg::CNT_W;
    localparam int SW = fpba_pkg::SZ_W;
    localparam int AB = fpba_pkg::ADDR_BITS;

    // configuration
    logic [fpba_pkg::POL_W-1:0] r_policy;
    logic [SW-1:0]              r_limit;
    logic [fpba_pkg::HDR_W-1:0] r_hdr;

    // allocator state
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_top;
    logic [IW-1:0] r_cur;
    logic          r_cur_ok;

    fpba_pkg::t_state r_state, n_state;

    // transaction
    logic          r_op;
    logic [SW-1:0] r_size;
    logic [AB-1:0] r_fa;
    logic [IW-1:0] r_s;
    logic [CW-1:0] r_step;

    // scan capture
    logic          r_found;
    logic [IW-1:0] r_pidx;
    logic [SW-1:0] r_pstart, r_plen;
    logic          r_last_free;
    logic [SW-1:0] r_last_start, r_last_len;
    logic          r_prev_free;
    logic [SW-1:0] r_prev_start, r_prev_len;
    logic          r_look_next, r_next_free;
    logic [SW-1:0] r_next_len;

    fpba_pkg::t_cell_cmd r_op1, r_op2, r_op3;
    fpba_pkg::t_cell_cmd n_op1, n_op2, n_op3;
    fpba_pkg::t_cell_cmd w_cmd;
    fpba_pkg::t_entry    w_head;

    logic [2:0]  r_res_status;
    logic [15:0] r_res_addr;
    logic [16:0] r_res_granted;
    logic        r_res_grew, r_res_split;
    logic [1:0]  r_res_merges;

    logic w_cfg_wr, w_in_acc, w_out_free;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~o_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpba_pkg::POL_FIRST;
            r_limit  <= fpba_pkg::HEAP_SPAN;
            r_hdr    <= fpba_pkg::HDR_W'(32);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                fpba_pkg::REG_FIT_POLICY:   r_policy <= pwdata[fpba_pkg::POL_W-1:0];
                fpba_pkg::REG_HEAP_LIMIT:   r_limit  <= pwdata[SW-1:0];
                fpba_pkg::REG_HEADER_BYTES: r_hdr    <= pwdata[fpba_pkg::HDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fpba_pkg::REG_FIT_POLICY:
                prdata = fpba_pkg::PDATA_W'(r_policy);
            fpba_pkg::REG_HEAP_LIMIT:
                prdata = fpba_pkg::PDATA_W'(r_limit);
            fpba_pkg::REG_HEADER_BYTES:
                prdata = fpba_pkg::PDATA_W'(r_hdr);
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpba_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_operation == fpba_pkg::OP_ALLOC && i_request_size == '0) begin
                        n_state = fpba_pkg::S_DONE;
                    end else begin
                        n_state = fpba_pkg::S_SCAN;
                    end
                end
            end
            fpba_pkg::S_SCAN: begin
                if (r_step == CW'(fpba_pkg::MAX_BLOCKS - 1)) begin
                    n_state = fpba_pkg::S_DECIDE;
                end
            end
            fpba_pkg::S_DECIDE: n_state = fpba_pkg::S_EXEC1;
            fpba_pkg::S_EXEC1:  n_state = fpba_pkg::S_EXEC2;
            fpba_pkg::S_EXEC2:  n_state = fpba_pkg::S_EXEC3;
            fpba_pkg::S_EXEC3:  n_state = fpba_pkg::S_DONE;
            fpba_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = fpba_pkg::S_IDLE;
                end
            end
            default: n_state = fpba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_cmd      = '0;
        w_cmd.op   = fpba_pkg::CELL_HOLD;
        case (r_state)
            fpba_pkg::S_IDLE:  o_in_stall = 1'b0;
            fpba_pkg::S_SCAN:  w_cmd.op = fpba_pkg::CELL_ROT;
            fpba_pkg::S_EXEC1: w_cmd = r_op1;
            fpba_pkg::S_EXEC2: w_cmd = r_op2;
            fpba_pkg::S_EXEC3: w_cmd = r_op3;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    fpba_table u_table (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_head (w_head)
    );

    // ---------------------------------------------------------------- scan
    logic [IW-1:0] w_k;
    logic [SW-1:0] w_h;
    logic          w_valid, w_fit, w_take, w_match;
    logic [SW-1:0] w_daddr;

    assign w_k     = r_step[IW-1:0];
    assign w_h     = SW'(r_hdr & fpba_pkg::HDR_MASK);
    assign w_valid = r_step < r_count;
    assign w_fit   = w_valid && w_head.free && (w_head.len >= r_size);
    assign w_daddr = w_head.start + w_h;
    assign w_match = w_valid && !w_head.free && (w_daddr[AB-1:0] == r_fa) && !r_found;

    always_comb begin
        case (r_policy)
            fpba_pkg::POL_FIRST: w_take = !r_found;
            // a fit at or past the cursor beats one that wrapped
            fpba_pkg::POL_NEXT:  w_take = !r_found || (r_pidx < r_s && w_k >= r_s);
            fpba_pkg::POL_BEST:  w_take = !r_found || (w_head.len < r_plen);
            fpba_pkg::POL_WORST: w_take = !r_found || (w_head.len > r_plen);
            default:             w_take = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- decide
    logic [SW:0]   w_split_need, w_end;
    logic          w_split, w_room;
    logic [SW-1:0] w_lim, w_rest, w_nstart, w_aaddr, w_gaddr;
    logic [SW-1:0] w_l0, w_l, w_bstart;
    logic [IW-1:0] w_base, w_j2, w_c1, w_c2;
    logic          w_cnt_full;

    assign w_cnt_full   = r_count >= CW'(fpba_pkg::MAX_BLOCKS);
    assign w_split_need = {1'b0, r_size} + {1'b0, w_h} + fpba_pkg::SPLIT_SLACK;
    assign w_split      = ({1'b0, r_plen} >= w_split_need) && !w_cnt_full;
    assign w_rest       = r_plen - r_size - w_h;
    assign w_nstart     = r_pstart + w_h + r_size;
    assign w_aaddr      = r_pstart + w_h;
    assign w_lim        = (r_limit > fpba_pkg::HEAP_SPAN) ? fpba_pkg::HEAP_SPAN : r_limit;
    assign w_end        = {1'b0, r_top} + {1'b0, w_h} + {1'b0, r_size};
    assign w_room       = !w_cnt_full && (w_end <= {1'b0, w_lim});
    assign w_gaddr      = r_top + w_h;

    assign w_l0     = r_prev_free ? (r_prev_len + w_h + r_plen) : r_plen;
    assign w_l      = r_next_free ? (w_l0 + w_h + r_next_len) : w_l0;
    assign w_base   = r_prev_free ? (r_pidx - IW'(1)) : r_pidx;
    assign w_bstart = r_prev_free ? r_prev_start : r_pstart;
    assign w_j2     = r_prev_free ? r_pidx : (r_pidx + IW'(1));
    assign w_c1     = (r_prev_free && r_cur >= r_pidx) ? (r_cur - IW'(1)) : r_cur;
    assign w_c2     = (r_next_free && w_c1 >= w_j2) ? (w_c1 - IW'(1)) : w_c1;

    // cell commands applied in the states EXEC1 to EXEC3 after the decision
    always_comb begin
        n_op1 = '{op: fpba_pkg::CELL_HOLD, idx: '0, ent: '0};
        n_op2 = '{op: fpba_pkg::CELL_HOLD, idx: '0, ent: '0};
        n_op3 = '{op: fpba_pkg::CELL_HOLD, idx: '0, ent: '0};
        if (r_op == fpba_pkg::OP_ALLOC) begin
            if (r_found) begin
                n_op1 = '{op: fpba_pkg::CELL_WR, idx: r_pidx,
                          ent: '{start: r_pstart,
                                 len: (w_split ? r_size : r_plen),
                                 free: 1'b0}};
                if (w_split) begin
                    n_op2 = '{op: fpba_pkg::CELL_INS, idx: r_pidx + IW'(1),
                              ent: '{start: w_nstart, len: w_rest, free: 1'b1}};
                end
            end else if (w_room) begin
                n_op1 = '{op: fpba_pkg::CELL_WR, idx: r_count[IW-1:0],
                          ent: '{start: r_top, len: r_size, free: 1'b0}};
            end
        end else if (r_found) begin
            if (r_prev_free) begin
                n_op1 = '{op: fpba_pkg::CELL_DEL, idx: r_pidx, ent: '0};
            end
            if (r_next_free) begin
                n_op2 = '{op: fpba_pkg::CELL_DEL, idx: w_j2, ent: '0};
            end
            n_op3 = '{op: fpba_pkg::CELL_WR, idx: w_base,
                      ent: '{start: w_bstart, len: w_l, free: 1'b1}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_top       <= '0;
            r_cur       <= '0;
            r_cur_ok    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                fpba_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_op        <= i_operation;
                        r_size      <= ({1'b0, i_request_size} + fpba_pkg::ALIGN_ADD)
                                       & fpba_pkg::ALIGN_MASK;
                        r_fa        <= i_free_address;
                        r_s         <= (r_cur_ok && CW'(r_cur) < r_count) ? r_cur : '0;
                        r_step      <= '0;
                        r_found     <= 1'b0;
                        r_pidx      <= '0;
                        r_last_free <= 1'b0;
                        r_prev_free <= 1'b0;
                        r_look_next <= 1'b0;
                        r_next_free <= 1'b0;
                        r_res_status  <= fpba_pkg::ST_ZERO;
                        r_res_addr    <= '0;
                        r_res_granted <= '0;
                        r_res_grew    <= 1'b0;
                        r_res_split   <= 1'b0;
                        r_res_merges  <= '0;
                    end
                end
                fpba_pkg::S_SCAN: begin
                    r_step <= r_step + CW'(1);
                    if (r_op == fpba_pkg::OP_ALLOC) begin
                        if (w_fit && w_take) begin
                            r_found  <= 1'b1;
                            r_pidx   <= w_k;
                            r_pstart <= w_head.start;
                            r_plen   <= w_head.len;
                        end
                    end else begin
                        if (w_match) begin
                            r_found      <= 1'b1;
                            r_pidx       <= w_k;
                            r_pstart     <= w_head.start;
                            r_plen       <= w_head.len;
                            r_prev_free  <= (w_k != '0) && r_last_free;
                            r_prev_start <= r_last_start;
                            r_prev_len   <= r_last_len;
                            r_look_next  <= 1'b1;
                        end else if (r_look_next) begin
                            r_look_next <= 1'b0;
                            r_next_free <= w_valid && w_head.free;
                            r_next_len  <= w_head.len;
                        end
                    end
                    r_last_free  <= w_head.free;
                    r_last_start <= w_head.start;
                    r_last_len   <= w_head.len;
                end
                fpba_pkg::S_DECIDE: begin
                    r_op1 <= n_op1;
                    r_op2 <= n_op2;
                    r_op3 <= n_op3;
                    if (r_op == fpba_pkg::OP_ALLOC) begin
                        if (r_found) begin
                            if (w_split) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_cur         <= r_pidx;
                            r_cur_ok      <= 1'b1;
                            r_res_status  <= fpba_pkg::ST_ALLOCATED;
                            r_res_addr    <= w_aaddr[AB-1:0];
                            r_res_granted <= w_split ? r_size : r_plen;
                            r_res_split   <= w_split;
                        end else if (w_room) begin
                            r_count       <= r_count + CW'(1);
                            r_top         <= w_end[SW-1:0];
                            r_cur         <= r_count[IW-1:0];
                            r_cur_ok      <= 1'b1;
                            r_res_status  <= fpba_pkg::ST_ALLOCATED;
                            r_res_addr    <= w_gaddr[AB-1:0];
                            r_res_granted <= r_size;
                            r_res_grew    <= 1'b1;
                        end else begin
                            r_res_status <= fpba_pkg::ST_NO_MEM;
                        end
                    end else begin
                        if (r_found) begin
                            r_count <= r_count - CW'(r_prev_free) - CW'(r_next_free);
                            r_cur   <= w_c2;
                            r_res_status  <= fpba_pkg::ST_FREED;
                            r_res_granted <= w_l;
                            r_res_merges  <= 2'(r_prev_free) + 2'(r_next_free);
                        end else begin
                            r_res_status <= fpba_pkg::ST_BAD_FREE;
                        end
                    end
                end
                fpba_pkg::S_DONE: begin
                    if (w_out_free) begin
                        o_out_valid    <= 1'b1;
                        o_status       <= r_res_status;
                        o_data_address <= r_res_addr;
                        o_granted_size <= r_res_granted;
                        o_heap_grew    <= r_res_grew;
                        o_block_split  <= r_res_split;
                        o_merges_done  <= r_res_merges;
                    end
                end
                default: ;
            endcase
            if (o_out_valid && !i_out_stall &&
                !(r_state == fpba_pkg::S_DONE && w_out_free)) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

### tb/tb_fit_policy_block_allocator.sv
// Self-checking testbench for the fit-policy block allocator.
module tb_fit_policy_block_allocator;

    typedef struct packed {
        logic [fpba_pkg::ST_W-1:0] status;
        logic [15:0]     addr;
        logic [16:0]     granted;
        logic            grew;
        logic            split;
        logic [1:0]      merges;
    } t_result;

    // allocator predictor with its own block table
    class alloc_scoreboard;
        logic [1:0]  policy;
        logic [16:0] limit;
        logic [6:0]  hdr_reg;
        logic [16:0] tstart [fpba_pkg::MAX_BLOCKS];
        logic [16:0] tlen   [fpba_pkg::MAX_BLOCKS];
        bit          tfree  [fpba_pkg::MAX_BLOCKS];
        int          nblk;
        logic [16:0] top;
        int          cursor;
        bit          cursor_ok;
        t_result     pending[$];
        int          errors;
        logic [15:0] live_addr[$];

        function new();
            policy = fpba_pkg::POL_FIRST; limit = 17'h10000; hdr_reg = 7'd32;
            nblk = 0; top = 0; cursor = 0; cursor_ok = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == fpba_pkg::REG_FIT_POLICY) policy = v[1:0];
            else if (idx == fpba_pkg::REG_HEAP_LIMIT) limit = v[16:0];
            else if (idx == fpba_pkg::REG_HEADER_BYTES) hdr_reg = v[6:0];
        endfunction

        function bit fits(int i, logic [16:0] sz);
            return tfree[i] && tlen[i] >= sz;
        endfunction

        function int pick_block(logic [16:0] sz);
            int p, s, k;
            p = -1;
            if (policy == fpba_pkg::POL_NEXT) begin
                s = (cursor_ok && cursor < nblk) ? cursor : 0;
                for (int i = 0; i < nblk; i++) begin
                    k = s + i;
                    if (k >= nblk) k -= nblk;
                    if (fits(k, sz)) return k;
                end
                return -1;
            end
            for (int i = 0; i < nblk; i++) begin
                if (!fits(i, sz)) continue;
                if (policy == fpba_pkg::POL_FIRST) return i;
                if (p < 0) p = i;
                else if (policy == fpba_pkg::POL_BEST && tlen[i] < tlen[p]) p = i;
                else if (policy == fpba_pkg::POL_WORST && tlen[i] > tlen[p]) p = i;
            end
            return p;
        endfunction

        function void absorb_next(int j, logic [16:0] h);
            tlen[j-1] = tlen[j-1] + h + tlen[j];
            for (int k = j; k < nblk - 1; k++) begin
                tstart[k] = tstart[k+1]; tlen[k] = tlen[k+1]; tfree[k] = tfree[k+1];
            end
            nblk--;
            if (cursor_ok && cursor >= j) cursor--;
        endfunction

        function void note_request(logic op, logic [15:0] rsz, logic [15:0] fa);
            t_result r;
            logic [16:0] h, sz, rest;
            logic [17:0] last, lim_c;
            int i, hit;
            r = '0;
            h = {10'd0, hdr_reg & fpba_pkg::HDR_MASK};
            lim_c = (limit > 17'h10000) ? 18'h10000 : {1'b0, limit};
            if (op == fpba_pkg::OP_ALLOC) begin
                sz = ({1'b0, rsz} + 17'd3) & fpba_pkg::ALIGN_MASK;
                if (sz == 0) r.status = fpba_pkg::ST_ZERO;
                else begin
                    i = pick_block(sz);
                    if (i >= 0) begin
                        tfree[i] = 0;
                        if ({1'b0, tlen[i]} >= {1'b0, sz} + h + 18'd4 &&
                            nblk < fpba_pkg::MAX_BLOCKS) begin
                            rest = tlen[i] - sz - h;
                            tlen[i] = sz;
                            for (int k = nblk; k > i + 1; k--) begin
                                tstart[k] = tstart[k-1]; tlen[k] = tlen[k-1];
                                tfree[k] = tfree[k-1];
                            end
                            tstart[i+1] = tstart[i] + h + sz;
                            tlen[i+1] = rest; tfree[i+1] = 1;
                            nblk++;
                            if (cursor_ok && cursor > i) cursor++;
                            r.split = 1;
                        end
                    end else begin
                        last = {1'b0, top} + h + sz;
                        if (nblk < fpba_pkg::MAX_BLOCKS && last <= lim_c) begin
                            i = nblk;
                            tstart[i] = top; tlen[i] = sz; tfree[i] = 0;
                            nblk++;
                            top = last[16:0];
                            r.grew = 1;
                        end
                    end
                    if (i >= 0) begin
                        cursor = i; cursor_ok = 1;
                        r.addr = 16'(tstart[i] + h);
                        r.granted = tlen[i];
                        r.status = fpba_pkg::ST_ALLOCATED;
                        live_addr.push_back(r.addr);
                    end else r.status = fpba_pkg::ST_NO_MEM;
                end
            end else begin
                hit = -1;
                for (int k = 0; k < nblk; k++)
                    if (!tfree[k] && 16'(tstart[k] + h) == fa) begin
                        hit = k;
                        break;
                    end
                if (hit < 0) r.status = fpba_pkg::ST_BAD_FREE;
                else begin
                    r.status = fpba_pkg::ST_FREED;
                    tfree[hit] = 1;
                    if (hit > 0 && tfree[hit-1]) begin
                        absorb_next(hit, h); hit--; r.merges++;
                    end
                    if (hit + 1 < nblk && tfree[hit+1]) begin
                        absorb_next(hit + 1, h); r.merges++;
                    end
                    r.granted = tlen[hit];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected %p actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [fpba_pkg::PADDR_W-1:0] paddr = '0;
    logic [fpba_pkg::PDATA_W-1:0] pwdata = '0;
    logic [fpba_pkg::PDATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 0, o_in_stall;
    logic i_operation = 0;
    logic [15:0] i_request_size = 0, i_free_address = 0;
    logic o_out_valid, i_out_stall = 0;
    logic [2:0] o_status;
    logic [15:0] o_data_address;
    logic [16:0] o_granted_size;
    logic o_heap_grew, o_block_split;
    logic [1:0] o_merges_done;

    alloc_scoreboard heap_sb = new();
    bit calm;

    fit_policy_block_allocator u_top (.*);

    always #2 i_clk = ~i_clk;

    // receiver: random stall, result check on accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            heap_sb.check_result({o_status, o_data_address, o_granted_size,
                                  o_heap_grew, o_block_split, o_merges_done});
    end
    always @(negedge i_clk)
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= fpba_pkg::PADDR_W'({idx, 2'b00}); pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        heap_sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_request(logic op, logic [15:0] rsz, logic [15:0] fa);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 34) @(negedge i_clk);
        i_in_valid <= 1; i_operation <= op; i_request_size <= rsz; i_free_address <= fa;
        do @(posedge i_clk); while (o_in_stall);
        heap_sb.note_request(op, rsz, fa);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic drain();
        while (heap_sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_ops(int n, int size_cap);
        int pick;
        logic [15:0] a;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_request(fpba_pkg::OP_ALLOC, 16'($urandom_range(size_cap)),
                             16'($urandom));
            else if (pick < 85 && heap_sb.live_addr.size() != 0) begin
                int j;
                j = $urandom_range(heap_sb.live_addr.size() - 1);
                a = heap_sb.live_addr[j];
                heap_sb.live_addr.delete(j);
                send_request(fpba_pkg::OP_FREE, 16'($urandom), a);
            end else if (pick < 92)
                send_request(fpba_pkg::OP_FREE, 16'($urandom), 16'($urandom));
            else
                send_request(fpba_pkg::OP_ALLOC, 16'($urandom), 16'($urandom));
        end
    endtask

    // allocation sizes get their own random value
    task automatic alloc_rand(int size_cap);
        send_request(fpba_pkg::OP_ALLOC, 16'($urandom_range(size_cap)), 16'($urandom));
    endtask

    initial begin
        calm = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: zero size, odd sizes, bad frees, growth, split and merges
        send_request(fpba_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
        send_request(fpba_pkg::OP_ALLOC, 16'd1, 16'd0);
        send_request(fpba_pkg::OP_ALLOC, 16'd100, 16'd0);
        send_request(fpba_pkg::OP_ALLOC, 16'd7, 16'd0);
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'd0);
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'hFFFF);
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'd32);
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'd32);   // double free
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'd68);
        send_request(fpba_pkg::OP_ALLOC, 16'd8, 16'd0);   // split of merged block
        send_request(fpba_pkg::OP_FREE, 16'd0, 16'd108);
        send_request(fpba_pkg::OP_ALLOC, 16'hFFFF, 16'd0);  // out of memory
        send_request(fpba_pkg::OP_ALLOC, 16'hFFFD, 16'd0);
        drain();

        write_reg(fpba_pkg::REG_HEADER_BYTES, 32'd7);   // low bits ignored
        write_reg(fpba_pkg::REG_HEAP_LIMIT, 32'h1FFFF); // clamped
        for (int pol = 0; pol < 4; pol++) begin
            write_reg(fpba_pkg::REG_FIT_POLICY, pol);
            calm = (pol == 2);
            random_ops(150, pol[0] ? 2000 : 300);
            drain();
            if (pol == 1) write_reg(fpba_pkg::REG_HEADER_BYTES, 32'd0);
            if (pol == 2) write_reg(fpba_pkg::REG_HEADER_BYTES, 32'd64);
        end
        calm = 0;
        write_reg(fpba_pkg::REG_HEAP_LIMIT, 32'd0);
        random_ops(30, 64);
        drain();
        write_reg(fpba_pkg::REG_HEAP_LIMIT, 32'd3000);
        write_reg(fpba_pkg::REG_HEADER_BYTES, 32'd4);
        for (int k = 0; k < 70; k++) alloc_rand(20); // fills the table
        random_ops(120, 200);
        drain();

        if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

### fit_policy_block_allocator.f
src/fpba_pkg.sv
src/fpba_cell.sv
src/fpba_table.sv
src/fit_policy_block_allocator.sv
tb/tb_fit_policy_block_allocator.sv
